@@ rtl/escpwm_pkg.sv @@
// Shared types, constants and codes for the ESC throttle to PWM duty core.
`default_nettype none
package escpwm_pkg;

  // Block sizing
  localparam int CHANNELS  = 4;
  localparam int DUTY_BITS = 14;

  // Field widths
  localparam int CH_W       = 4;
  localparam int PULSE_W    = 16;
  localparam int THR_W      = 17;
  localparam int ACT_W      = 3;
  localparam int DUTY_OUT_W = 14;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  // Channel index width into the pulse store
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Pulse store value after reset
  localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd1000;

  // Command codes on the input stream
  localparam logic [ACT_W-1:0] ACT_RAW  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UNI  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BI   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ARM  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_PERIOD  = 3'd0;
  localparam logic [2:0] REG_MIN     = 3'd1;
  localparam logic [2:0] REG_MAX     = 3'd2;
  localparam logic [2:0] REG_NEUTRAL = 3'd3;
  localparam logic [2:0] REG_DISARM  = 3'd4;

  // Operations handed from the front to the back
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  // Command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Configuration register bundle
  typedef struct packed {
    logic [PULSE_W-1:0] period;
    logic [PULSE_W-1:0] pmin;
    logic [PULSE_W-1:0] pmax;
    logic [PULSE_W-1:0] pneutral;
    logic [PULSE_W-1:0] disarm;
  } cfg_t;

  // One queued operation
  typedef struct packed {
    logic [1:0]         op;
    logic [CH_W-1:0]    ch;
    logic               ch_ok;
    logic [PULSE_W-1:0] pulse;
  } qent_t;

endpackage
`default_nettype wire

@@ rtl/escpwm_front.sv @@
// Command front end: accepts beats, maps throttles to pulses, queues operations.
`default_nettype none
module escpwm_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire escpwm_pkg::cfg_t             cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [escpwm_pkg::ACT_W-1:0] in_action,
  input  wire logic [escpwm_pkg::CH_W-1:0]  in_channel,
  input  wire logic [escpwm_pkg::PULSE_W-1:0] in_pulse,
  input  wire logic signed [escpwm_pkg::THR_W-1:0] in_throttle,
  input  wire logic                         in_arm,
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output escpwm_pkg::qent_t                 q_data
);
  import escpwm_pkg::*;

  localparam int PROD_W = 2 * THR_W;
  localparam int N_W    = 36;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_SUM  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  localparam logic signed [THR_W-1:0] T_ONE = 17'sd32768;
  localparam logic signed [THR_W-1:0] T_NEG = -17'sd32768;

  logic [1:0] state_r, state_nxt;
  logic       armed_r, armed_nxt;

  logic [ACT_W-1:0]         act_r;
  logic [CH_W-1:0]          ch_r;
  logic [PULSE_W-1:0]       praw_r;
  logic [PULSE_W-1:0]       base_r;
  logic signed [THR_W-1:0]  t_r;
  logic signed [THR_W-1:0]  diff_r;
  logic signed [PROD_W-1:0] prod_r;
  qent_t                    ent_r;

  logic                     ch_ok;
  logic signed [THR_W-1:0]  t_clamp;
  logic signed [THR_W-1:0]  diff_v;
  logic [PULSE_W-1:0]       base_v;
  logic signed [N_W-1:0]    n_v;
  logic [PULSE_W-1:0]       map_pulse;
  logic [PULSE_W-1:0]       sel_pulse;
  logic [PULSE_W-1:0]       fin_pulse;

  assign ch_ok    = ({1'b0, in_channel} < (CH_W + 1)'(CHANNELS));
  assign in_ready = (state_r == F_IDLE);
  assign q_valid  = (state_r == F_PUSH);
  assign q_data   = ent_r;

  // Clamp the throttle and pick the span per mode
  always_comb begin
    t_clamp = in_throttle;
    if (in_action == ACT_UNI) begin
      if (in_throttle < 17'sd0) t_clamp = 17'sd0;
      if (in_throttle > T_ONE)  t_clamp = T_ONE;
    end else begin
      if (in_throttle < T_NEG)  t_clamp = T_NEG;
      if (in_throttle > T_ONE)  t_clamp = T_ONE;
    end
    if (in_action == ACT_UNI) begin
      base_v = cfg.pmin;
      diff_v = $signed({1'b0, cfg.pmax}) - $signed({1'b0, cfg.pmin});
    end else if (!t_clamp[THR_W-1]) begin
      base_v = cfg.pneutral;
      diff_v = $signed({1'b0, cfg.pmax}) - $signed({1'b0, cfg.pneutral});
    end else begin
      base_v = cfg.pneutral;
      diff_v = $signed({1'b0, cfg.pneutral}) - $signed({1'b0, cfg.pmin});
    end
  end

  // Scale back from Q15, saturate, then clamp and apply the disarm override
  always_comb begin
    n_v = $signed({5'b0, base_r, 15'b0}) + N_W'(prod_r);
    if (n_v[N_W-1])       map_pulse = '0;
    else if (|n_v[34:31]) map_pulse = '1;
    else                  map_pulse = n_v[30:15];
    sel_pulse = (act_r == ACT_RAW) ? praw_r : map_pulse;
    fin_pulse = sel_pulse;
    if (fin_pulse < cfg.pmin) fin_pulse = cfg.pmin;
    if (fin_pulse > cfg.pmax) fin_pulse = cfg.pmax;
    if (!armed_r)             fin_pulse = cfg.disarm;
  end

  // Sequence one command at a time
  always_comb begin
    state_nxt = state_r;
    armed_nxt = armed_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_RAW:         if (ch_ok) state_nxt = F_SUM;
            ACT_UNI, ACT_BI: if (ch_ok) state_nxt = F_MUL;
            ACT_ARM: begin
              armed_nxt = in_arm;
              if (!in_arm) state_nxt = F_PUSH;
            end
            ACT_READ:        state_nxt = F_PUSH;
            default:         state_nxt = F_IDLE;
          endcase
        end
      end
      F_MUL:   state_nxt = F_SUM;
      F_SUM:   state_nxt = F_PUSH;
      F_PUSH:  if (q_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      armed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      armed_r <= armed_nxt;
    end
  end

  // Capture the beat and build the queued operation
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      act_r       <= in_action;
      ch_r        <= in_channel;
      praw_r      <= in_pulse;
      t_r         <= t_clamp;
      diff_r      <= diff_v;
      base_r      <= base_v;
      ent_r.ch    <= in_channel;
      ent_r.ch_ok <= ch_ok;
      ent_r.pulse <= cfg.disarm;
      ent_r.op    <= (in_action == ACT_READ) ? OP_READ : OP_SWEEP;
    end
    if (state_r == F_MUL) begin
      prod_r <= t_r * diff_r;
    end
    if (state_r == F_SUM) begin
      ent_r.op    <= OP_WRITE;
      ent_r.ch    <= ch_r;
      ent_r.pulse <= fin_pulse;
    end
  end

endmodule
`default_nettype wire

@@ rtl/escpwm_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none
module escpwm_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire escpwm_pkg::qent_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output escpwm_pkg::qent_t      pop_data
);
  import escpwm_pkg::*;

  qent_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [QPTR_W:0]     cnt_r;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push)
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (do_pop)
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

endmodule
`default_nettype wire

@@ rtl/escpwm_back.sv @@
// Back end: pulse store, bit-serial duty divider and result output register.
`default_nettype none
module escpwm_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire escpwm_pkg::cfg_t          cfg,
  input  wire logic                      q_valid,
  output logic                           q_ready,
  input  wire escpwm_pkg::qent_t         q_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [escpwm_pkg::CH_W-1:0]    out_channel,
  output logic [escpwm_pkg::PULSE_W-1:0] out_pulse,
  output logic [escpwm_pkg::DUTY_OUT_W-1:0] out_duty,
  output logic                           out_last
);
  import escpwm_pkg::*;

  localparam int NUM_W = PULSE_W + DUTY_BITS;
  localparam int CNT_W = $clog2(DUTY_BITS);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_LOAD = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_EMIT = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [PULSE_W-1:0]   store_r [CHANNELS];
  qent_t                ent_r;
  logic [PULSE_W-1:0]   pulse_r;
  logic [PULSE_W-1:0]   rem_r;
  logic [DUTY_BITS-1:0] numlo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CH_W-1:0]      emit_ch_r;
  logic                 out_valid_r;
  logic [CH_W-1:0]      out_ch_r;
  logic [PULSE_W-1:0]   out_pulse_r;
  logic [DUTY_OUT_W-1:0] out_duty_r;
  logic                 out_last_r;

  logic [PULSE_W-1:0]   per_v;
  logic [PULSE_W-1:0]   plim_v;
  logic [NUM_W-1:0]     num_v;
  logic [PULSE_W:0]     trial_v;
  logic                 qbit_v;
  logic                 is_last_v;
  logic                 emit_go;
  logic [CH_IDX_W-1:0]  q_idx;

  assign q_ready     = (state_r == B_IDLE);
  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_pulse   = out_pulse_r;
  assign out_duty    = out_duty_r;
  assign out_last    = out_last_r;
  assign q_idx       = q_data.ch[CH_IDX_W-1:0];

  // Divider setup: limit pulse to period, numerator is pulse times full scale
  always_comb begin
    per_v   = (cfg.period == '0) ? PULSE_W'(1) : cfg.period;
    plim_v  = (pulse_r > per_v) ? per_v : pulse_r;
    num_v   = {plim_v, DUTY_BITS'(0)} - NUM_W'(plim_v);
    trial_v = {rem_r, numlo_r[DUTY_BITS-1]};
    qbit_v  = (trial_v >= {1'b0, per_v});
  end

  assign is_last_v = (ent_r.op != OP_SWEEP) || (emit_ch_r == CH_W'(CHANNELS - 1));
  assign emit_go   = (state_r == B_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (q_valid) state_nxt = B_LOAD;
      B_LOAD:  state_nxt = B_DIV;
      B_DIV:   if (cnt_r == CNT_W'(DUTY_BITS - 1)) state_nxt = B_EMIT;
      B_EMIT:  if (emit_go && is_last_v) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state, pulse store and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) store_r[i] <= PULSE_RESET;
    end else begin
      state_r <= state_nxt;
      if (emit_go)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == B_IDLE && q_valid) begin
        if (q_data.op == OP_WRITE) store_r[q_idx] <= q_data.pulse;
        if (q_data.op == OP_SWEEP)
          for (int i = 0; i < CHANNELS; i++) store_r[i] <= q_data.pulse;
      end
    end
  end

  // Datapath: take the operation, divide one bit a cycle, load the result
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          ent_r     <= q_data;
          emit_ch_r <= '0;
          if (q_data.op == OP_READ)
            pulse_r <= q_data.ch_ok ? store_r[q_idx] : '0;
          else
            pulse_r <= q_data.pulse;
        end
      end
      B_LOAD: begin
        rem_r   <= num_v[NUM_W-1:DUTY_BITS];
        numlo_r <= num_v[DUTY_BITS-1:0];
        cnt_r   <= '0;
      end
      B_DIV: begin
        rem_r   <= qbit_v ? PULSE_W'(trial_v - {1'b0, per_v}) : trial_v[PULSE_W-1:0];
        numlo_r <= {numlo_r[DUTY_BITS-2:0], qbit_v};
        cnt_r   <= cnt_r + 1'b1;
      end
      B_EMIT: begin
        if (emit_go) begin
          out_ch_r    <= (ent_r.op == OP_SWEEP) ? emit_ch_r : ent_r.ch;
          out_pulse_r <= pulse_r;
          out_duty_r  <= DUTY_OUT_W'(numlo_r);
          out_last_r  <= is_last_v;
          emit_ch_r   <= emit_ch_r + 1'b1;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/esc_throttle_to_pwm_duty_core.sv @@
// Top level of the ESC throttle to PWM duty core: registers, front, queue, back.
`default_nettype none
// Maps per-channel ESC commands (raw pulse, unidirectional or bidirectional
// Q15 throttle, arm/disarm, readback) to a stored pulse width and a timer
// compare value duty = min(pulse, period) * (2^DUTY_BITS - 1) / period.
// The front end takes one command beat at a time: it accepts the beat, then
// a readback or disarm goes straight to the push state, a raw pulse first
// passes the sum state and a throttle passes the multiply and sum states
// (one registered 17x17 multiply); it then hands the operation to a two-entry
// queue. The back end takes each operation from the queue, loads and runs its
// bit-serial restoring divider (one quotient bit per cycle), then emits each
// result; a disarm sends CHANNELS results sharing one division. With the queue
// between them, the front end can take new commands while the back end works,
// until the queue fills. The result register lets the back end move on as soon
// as a beat is taken. Register writes must happen while the block is idle.
module esc_throttle_to_pwm_duty_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // channel[3:0], pulse_in_us[19:4], throttle[36:20], arm[37]
  input  wire logic [2:0]  in_tuser,  // action[2:0]
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata, // out_channel[3:0], pulse_us[19:4], duty[33:20]
  output logic             out_tlast,
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [escpwm_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [escpwm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [escpwm_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic             cfg_pready
);
  import escpwm_pkg::*;

  cfg_t               cfg_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;
  logic [PULSE_W-1:0] rd_v;

  logic               q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  qent_t              q_in_data, q_out_data;

  logic [CH_W-1:0]       res_ch;
  logic [PULSE_W-1:0]    res_pulse;
  logic [DUTY_OUT_W-1:0] res_duty;

  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period   <= 16'd20000;
      cfg_r.pmin     <= 16'd1000;
      cfg_r.pmax     <= 16'd2000;
      cfg_r.pneutral <= 16'd1500;
      cfg_r.disarm   <= 16'd1000;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PERIOD:  cfg_r.period   <= cfg_pwdata[PULSE_W-1:0];
        REG_MIN:     cfg_r.pmin     <= cfg_pwdata[PULSE_W-1:0];
        REG_MAX:     cfg_r.pmax     <= cfg_pwdata[PULSE_W-1:0];
        REG_NEUTRAL: cfg_r.pneutral <= cfg_pwdata[PULSE_W-1:0];
        REG_DISARM:  cfg_r.disarm   <= cfg_pwdata[PULSE_W-1:0];
        default:     cfg_r          <= cfg_r;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_PERIOD:  rd_v = cfg_r.period;
      REG_MIN:     rd_v = cfg_r.pmin;
      REG_MAX:     rd_v = cfg_r.pmax;
      REG_NEUTRAL: rd_v = cfg_r.pneutral;
      REG_DISARM:  rd_v = cfg_r.disarm;
      default:     rd_v = '0;
    endcase
  end
  assign cfg_prdata = CFG_DW'(rd_v);

  escpwm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_action   (in_tuser),
    .in_channel  (in_tdata[3:0]),
    .in_pulse    (in_tdata[19:4]),
    .in_throttle ($signed(in_tdata[36:20])),
    .in_arm      (in_tdata[37]),
    .q_valid     (q_in_valid),
    .q_ready     (q_in_ready),
    .q_data      (q_in_data)
  );

  escpwm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  escpwm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_out_valid),
    .q_ready     (q_out_ready),
    .q_data      (q_out_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_channel (res_ch),
    .out_pulse   (res_pulse),
    .out_duty    (res_duty),
    .out_last    (out_tlast)
  );

  // Pack the result beat
  assign out_tdata = {6'b0, res_duty, res_pulse, res_ch};

endmodule
`default_nettype wire
